@@ rtl/eqsc_pkg.sv @@
// ----------------------------------------------------------------------------
// eqsc_pkg
// Shared types and constants of the band equalizer scan controller.
// ----------------------------------------------------------------------------
package eqsc_pkg;

   // fixed geometry of the analyzer front end
   localparam int BAND_COUNT    = 7;
   localparam int SAMPLE_FIELDS = 4;
   localparam int TICK_BITS     = 8;
   localparam int BAND_BITS     = 3;
   localparam int CHAN_BITS     = 3;
   localparam int QCHAN_BITS    = 2;

   // register map, word index of each register
   localparam logic [2:0] REG_ACTIVE_CHANNELS   = 3'd0;
   localparam logic [2:0] REG_RESET_HOLD_TICKS  = 3'd1;
   localparam logic [2:0] REG_STROBE_LEAD_TICKS = 3'd2;
   localparam logic [2:0] REG_SETTLE_TICKS      = 3'd3;
   localparam logic [2:0] REG_STROBE_TAIL_TICKS = 3'd4;

   // register reset values
   localparam logic [CHAN_BITS-1:0] ACTIVE_CHANNELS_RST   = 3'd1;
   localparam logic [TICK_BITS-1:0] RESET_HOLD_TICKS_RST  = 8'd18;
   localparam logic [TICK_BITS-1:0] STROBE_LEAD_TICKS_RST = 8'd54;
   localparam logic [TICK_BITS-1:0] SETTLE_TICKS_RST      = 8'd36;
   localparam logic [TICK_BITS-1:0] STROBE_TAIL_TICKS_RST = 8'd36;

   // scan phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_RESET  = 5'b00010,
      PH_LEAD   = 5'b00100,
      PH_SETTLE = 5'b01000,
      PH_TAIL   = 5'b10000
   } phase_type;

   // phase durations seen by the sequencer
   typedef struct packed {
      logic [TICK_BITS-1:0] reset_hold;
      logic [TICK_BITS-1:0] strobe_lead;
      logic [TICK_BITS-1:0] settle;
      logic [TICK_BITS-1:0] strobe_tail;
   } timing_type;

   // sequencer to lanes and output stage
   typedef struct packed {
      logic                 capture;
      logic                 done;
      logic [BAND_BITS-1:0] band;
      logic                 reset_pin;
      logic                 strobe_pin;
      logic                 busy;
   } seq_ctl_type;

endpackage

@@ rtl/band_equalizer_scan_controller_top.sv @@
// ----------------------------------------------------------------------------
// band_equalizer_scan_controller_top
// Strobe/reset scan controller for seven-band analyzer chips, with
// per-channel band capture and volume averaging.
// ----------------------------------------------------------------------------
// Each request word is one timing tick and each tick returns one response
// word. The block takes a word in every unstalled cycle and answers in the
// next cycle through a registered output stage; req_stall rises only while a
// response is held by rsp_stall. The scan runs in one phase sequencer that
// advances one step per tick; each channel has a lane that stores its seven
// band samples and keeps a running band sum, so the volume at scan end is
// one multiply by the reciprocal of seven. Configuration is written over the
// csr_ port, pready is always high, registers lie at byte address 4*index.
module band_equalizer_scan_controller_top #(
   parameter int MAX_CHANNELS = 4,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_start_scan,
   input  logic [SAMPLE_BITS-1:0]   req_sample_ch0,
   input  logic [SAMPLE_BITS-1:0]   req_sample_ch1,
   input  logic [SAMPLE_BITS-1:0]   req_sample_ch2,
   input  logic [SAMPLE_BITS-1:0]   req_sample_ch3,
   input  logic [1:0]               req_query_channel,
   input  logic [2:0]               req_query_band,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_reset_out,
   output logic                     rsp_strobe_out,
   output logic                     rsp_busy_res,
   output logic                     rsp_scan_done,
   output logic [SAMPLE_BITS-1:0]   rsp_band_value,
   output logic [SAMPLE_BITS-1:0]   rsp_channel_volume,
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [4:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int LANES = (MAX_CHANNELS < eqsc_pkg::SAMPLE_FIELDS) ?
                          MAX_CHANNELS : eqsc_pkg::SAMPLE_FIELDS;

   logic [eqsc_pkg::CHAN_BITS-1:0] active_channels_ff;
   logic [eqsc_pkg::TICK_BITS-1:0] reset_hold_ff;
   logic [eqsc_pkg::TICK_BITS-1:0] strobe_lead_ff;
   logic [eqsc_pkg::TICK_BITS-1:0] settle_ff;
   logic [eqsc_pkg::TICK_BITS-1:0] strobe_tail_ff;

   logic                           cfg_write;
   logic [2:0]                     cfg_index;
   logic                           tick;
   logic [eqsc_pkg::CHAN_BITS-1:0] chan_count;
   eqsc_pkg::timing_type           timing;
   eqsc_pkg::seq_ctl_type          ctl;

   logic [SAMPLE_BITS-1:0] sample_arr [eqsc_pkg::SAMPLE_FIELDS];
   logic [SAMPLE_BITS-1:0] lane_band  [eqsc_pkg::SAMPLE_FIELDS];
   logic [SAMPLE_BITS-1:0] lane_vol   [eqsc_pkg::SAMPLE_FIELDS];
   logic [SAMPLE_BITS-1:0] band_value;
   logic [SAMPLE_BITS-1:0] channel_volume;

   logic                   rsp_valid_ff;
   logic                   reset_out_ff;
   logic                   strobe_out_ff;
   logic                   busy_res_ff;
   logic                   scan_done_ff;
   logic [SAMPLE_BITS-1:0] band_value_ff;
   logic [SAMPLE_BITS-1:0] channel_volume_ff;

   // configuration write decode
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_channels_ff <= eqsc_pkg::ACTIVE_CHANNELS_RST;
         reset_hold_ff      <= eqsc_pkg::RESET_HOLD_TICKS_RST;
         strobe_lead_ff     <= eqsc_pkg::STROBE_LEAD_TICKS_RST;
         settle_ff          <= eqsc_pkg::SETTLE_TICKS_RST;
         strobe_tail_ff     <= eqsc_pkg::STROBE_TAIL_TICKS_RST;
      end else if (cfg_write) begin
         unique case (cfg_index)
            eqsc_pkg::REG_ACTIVE_CHANNELS:
               active_channels_ff <= csr_pwdata[eqsc_pkg::CHAN_BITS-1:0];
            eqsc_pkg::REG_RESET_HOLD_TICKS:
               reset_hold_ff <= csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
            eqsc_pkg::REG_STROBE_LEAD_TICKS:
               strobe_lead_ff <= csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
            eqsc_pkg::REG_SETTLE_TICKS:
               settle_ff <= csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
            eqsc_pkg::REG_STROBE_TAIL_TICKS:
               strobe_tail_ff <= csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // configuration read
   always_comb begin
      unique case (cfg_index)
         eqsc_pkg::REG_ACTIVE_CHANNELS:   csr_prdata = 32'(active_channels_ff);
         eqsc_pkg::REG_RESET_HOLD_TICKS:  csr_prdata = 32'(reset_hold_ff);
         eqsc_pkg::REG_STROBE_LEAD_TICKS: csr_prdata = 32'(strobe_lead_ff);
         eqsc_pkg::REG_SETTLE_TICKS:      csr_prdata = 32'(settle_ff);
         eqsc_pkg::REG_STROBE_TAIL_TICKS: csr_prdata = 32'(strobe_tail_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   // active channel count clamped to the lanes built
   assign chan_count = (active_channels_ff > eqsc_pkg::CHAN_BITS'(LANES)) ?
                       eqsc_pkg::CHAN_BITS'(LANES) : active_channels_ff;

   assign timing.reset_hold  = reset_hold_ff;
   assign timing.strobe_lead = strobe_lead_ff;
   assign timing.settle      = settle_ff;
   assign timing.strobe_tail = strobe_tail_ff;

   // a word enters whenever the output register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign tick      = req_valid && !req_stall;

   eqsc_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .start_scan (req_start_scan),
      .timing     (timing),
      .ctl        (ctl)
   );

   assign sample_arr[0] = req_sample_ch0;
   assign sample_arr[1] = req_sample_ch1;
   assign sample_arr[2] = req_sample_ch2;
   assign sample_arr[3] = req_sample_ch3;

   // one lane per channel, unused slots read zero
   for (genvar l = 0; l < eqsc_pkg::SAMPLE_FIELDS; l++) begin : g_lane
      if (l < LANES) begin : g_on
         eqsc_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .tick       (tick),
            .ctl        (ctl),
            .active     (eqsc_pkg::CHAN_BITS'(l) < chan_count),
            .sample     (sample_arr[l]),
            .query_band (req_query_band),
            .rd_band    (lane_band[l]),
            .rd_vol     (lane_vol[l])
         );
      end else begin : g_off
         assign lane_band[l] = '0;
         assign lane_vol[l]  = '0;
      end
   end

   eqsc_query_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .lane_band      (lane_band),
      .lane_vol       (lane_vol),
      .query_channel  (req_query_channel),
      .chan_count     (chan_count),
      .band_value     (band_value),
      .channel_volume (channel_volume)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         reset_out_ff      <= ctl.reset_pin;
         strobe_out_ff     <= ctl.strobe_pin;
         busy_res_ff       <= ctl.busy;
         scan_done_ff      <= ctl.done;
         band_value_ff     <= band_value;
         channel_volume_ff <= channel_volume;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reset_out      = reset_out_ff;
   assign rsp_strobe_out     = strobe_out_ff;
   assign rsp_busy_res       = busy_res_ff;
   assign rsp_scan_done      = scan_done_ff;
   assign rsp_band_value     = band_value_ff;
   assign rsp_channel_volume = channel_volume_ff;

endmodule

@@ rtl/eqsc_sequencer.sv @@
// ----------------------------------------------------------------------------
// eqsc_sequencer
// Phase state machine that drives the analyzer pins and times the captures.
// ----------------------------------------------------------------------------
module eqsc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  logic                   start_scan,
   input  eqsc_pkg::timing_type   timing,
   output eqsc_pkg::seq_ctl_type  ctl
);

   eqsc_pkg::phase_type                phase_ff, phase_in;
   logic [eqsc_pkg::TICK_BITS-1:0]     ticks_ff, ticks_in;
   logic [eqsc_pkg::BAND_BITS-1:0]     band_ff, band_in;
   logic [eqsc_pkg::TICK_BITS-1:0]     dur_raw;
   logic [eqsc_pkg::TICK_BITS-1:0]     dur;
   logic                               capture;
   logic                               done;

   // duration of the current phase, zero counts as one tick
   always_comb begin
      unique case (phase_ff)
         eqsc_pkg::PH_RESET:  dur_raw = timing.reset_hold;
         eqsc_pkg::PH_LEAD:   dur_raw = timing.strobe_lead;
         eqsc_pkg::PH_SETTLE: dur_raw = timing.settle;
         default:             dur_raw = timing.strobe_tail;
      endcase
      dur = (dur_raw == '0) ? eqsc_pkg::TICK_BITS'(1) : dur_raw;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      band_in  = band_ff;
      capture  = 1'b0;
      done     = 1'b0;
      unique case (phase_ff)
         eqsc_pkg::PH_IDLE: begin
            if (start_scan) begin
               phase_in = eqsc_pkg::PH_RESET;
               ticks_in = eqsc_pkg::TICK_BITS'(1);
               band_in  = '0;
            end
         end
         default: begin
            if (ticks_ff < dur) begin
               ticks_in = ticks_ff + eqsc_pkg::TICK_BITS'(1);
            end else begin
               ticks_in = eqsc_pkg::TICK_BITS'(1);
               unique case (phase_ff)
                  eqsc_pkg::PH_RESET: begin
                     phase_in = eqsc_pkg::PH_LEAD;
                  end
                  eqsc_pkg::PH_LEAD: begin
                     phase_in = eqsc_pkg::PH_SETTLE;
                     band_in  = '0;
                  end
                  eqsc_pkg::PH_SETTLE: begin
                     phase_in = eqsc_pkg::PH_TAIL;
                     capture  = 1'b1;
                  end
                  default: begin
                     if (band_ff < eqsc_pkg::BAND_BITS'(eqsc_pkg::BAND_COUNT - 1)) begin
                        phase_in = eqsc_pkg::PH_SETTLE;
                        band_in  = band_ff + eqsc_pkg::BAND_BITS'(1);
                     end else begin
                        phase_in = eqsc_pkg::PH_IDLE;
                        ticks_in = '0;
                        band_in  = '0;
                        done     = 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // state registers, advance once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= eqsc_pkg::PH_IDLE;
         ticks_ff <= '0;
         band_ff  <= '0;
      end else if (tick) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         band_ff  <= band_in;
      end
   end

   // control word, pin levels follow the phase after this tick
   always_comb begin
      ctl.capture    = capture;
      ctl.done       = done;
      ctl.band       = band_ff;
      ctl.reset_pin  = (phase_in == eqsc_pkg::PH_RESET);
      ctl.strobe_pin = (phase_in == eqsc_pkg::PH_LEAD) || (phase_in == eqsc_pkg::PH_TAIL);
      ctl.busy       = (phase_in != eqsc_pkg::PH_IDLE);
   end

endmodule

@@ rtl/eqsc_lane.sv @@
// ----------------------------------------------------------------------------
// eqsc_lane
// One analyzer channel: band samples, running band sum and volume.
// ----------------------------------------------------------------------------
module eqsc_lane #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick,
   input  eqsc_pkg::seq_ctl_type               ctl,
   input  logic                                active,
   input  logic [SAMPLE_BITS-1:0]              sample,
   input  logic [eqsc_pkg::BAND_BITS-1:0]      query_band,
   output logic [SAMPLE_BITS-1:0]              rd_band,
   output logic [SAMPLE_BITS-1:0]              rd_vol
);

   // sum of seven samples, and a reciprocal of seven exact over that range
   localparam int SUM_BITS   = SAMPLE_BITS + 3;
   localparam int DIV_SHIFT  = SUM_BITS + 3;
   localparam int RECIP_BITS = DIV_SHIFT - 2;
   localparam int RECIP_INT  = ((1 << DIV_SHIFT) + 6) / 7;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_INT);

   logic [SAMPLE_BITS-1:0] band_ff [eqsc_pkg::BAND_COUNT];
   logic [SAMPLE_BITS-1:0] band_in [eqsc_pkg::BAND_COUNT];
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] vol_ff, vol_in;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic [PROD_BITS-1:0]   prod;
   logic                   write_en;

   assign write_en = ctl.capture && active;

   // band samples with this tick's capture forwarded
   always_comb begin
      for (int b = 0; b < eqsc_pkg::BAND_COUNT; b++) begin
         band_in[b] = (write_en && (ctl.band == eqsc_pkg::BAND_BITS'(b))) ? sample : band_ff[b];
      end
   end

   // running sum tracks the stored samples, old value out, new value in
   assign old_sample = band_ff[ctl.band];
   assign sum_in = write_en ?
                   (sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(sample)) : sum_ff;

   // divide by seven through the reciprocal
   assign prod   = PROD_BITS'(sum_ff) * PROD_BITS'(RECIP);
   assign vol_in = (ctl.done && active) ? prod[DIV_SHIFT +: SAMPLE_BITS] : vol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < eqsc_pkg::BAND_COUNT; b++) begin
            band_ff[b] <= '0;
         end
         sum_ff <= '0;
         vol_ff <= '0;
      end else if (tick) begin
         for (int b = 0; b < eqsc_pkg::BAND_COUNT; b++) begin
            band_ff[b] <= band_in[b];
         end
         sum_ff <= sum_in;
         vol_ff <= vol_in;
      end
   end

   // query read of the updated values, band seven reads zero
   assign rd_band = (query_band < eqsc_pkg::BAND_BITS'(eqsc_pkg::BAND_COUNT)) ?
                    band_in[query_band] : '0;
   assign rd_vol  = vol_in;

endmodule

@@ rtl/eqsc_query_merge.sv @@
// ----------------------------------------------------------------------------
// eqsc_query_merge
// Picks the queried channel out of the lanes, zero for inactive channels.
// ----------------------------------------------------------------------------
module eqsc_query_merge #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic [SAMPLE_BITS-1:0]            lane_band [eqsc_pkg::SAMPLE_FIELDS],
   input  logic [SAMPLE_BITS-1:0]            lane_vol  [eqsc_pkg::SAMPLE_FIELDS],
   input  logic [eqsc_pkg::QCHAN_BITS-1:0]   query_channel,
   input  logic [eqsc_pkg::CHAN_BITS-1:0]    chan_count,
   output logic [SAMPLE_BITS-1:0]            band_value,
   output logic [SAMPLE_BITS-1:0]            channel_volume
);

   logic in_range;

   // channel must lie below the active count
   assign in_range = eqsc_pkg::CHAN_BITS'(query_channel) < chan_count;

   assign band_value     = in_range ? lane_band[query_channel] : '0;
   assign channel_volume = in_range ? lane_vol[query_channel]  : '0;

endmodule

@@ tb/eqsc_checker.sv @@
// ----------------------------------------------------------------------------
// eqsc_checker
// Scoreboard for the band equalizer scan controller. Follows the register
// port, runs its own model of the scan sequencer and the channel stores for
// every accepted request word, and compares each response word field by
// field with the oldest prediction. Register reads are checked as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eqsc_checker #(
   parameter int MAX_CHANNELS = 4,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_start_scan,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch0,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch1,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch2,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch3,
   input  logic [1:0]             req_query_channel,
   input  logic [2:0]             req_query_band,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_reset_out,
   input  logic                   rsp_strobe_out,
   input  logic                   rsp_busy_res,
   input  logic                   rsp_scan_done,
   input  logic [SAMPLE_BITS-1:0] rsp_band_value,
   input  logic [SAMPLE_BITS-1:0] rsp_channel_volume,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [4:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   input  logic [31:0]            csr_prdata,
   input  logic                   csr_pready,
   output int                     fail_count = 0,
   output int                     pending_words = 0,
   output int                     scans_seen = 0
);

   // channels that can really be sampled
   localparam int LANES = (MAX_CHANNELS < eqsc_pkg::SAMPLE_FIELDS) ?
                          MAX_CHANNELS : eqsc_pkg::SAMPLE_FIELDS;
   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic                   reset_pin;
      logic                   strobe_pin;
      logic                   busy;
      logic                   done;
      logic [SAMPLE_BITS-1:0] band_value;
      logic [SAMPLE_BITS-1:0] volume;
   } readout_type;

   // register copies
   logic [eqsc_pkg::CHAN_BITS-1:0] cfg_channels;
   logic [eqsc_pkg::TICK_BITS-1:0] cfg_hold;
   logic [eqsc_pkg::TICK_BITS-1:0] cfg_lead;
   logic [eqsc_pkg::TICK_BITS-1:0] cfg_settle;
   logic [eqsc_pkg::TICK_BITS-1:0] cfg_tail;

   // sequencer and store copies
   eqsc_pkg::phase_type            scan_ph;
   logic [eqsc_pkg::TICK_BITS-1:0] ph_ticks;
   logic [eqsc_pkg::BAND_BITS-1:0] band_idx;
   logic [SAMPLE_BITS-1:0]         band_mem [MAX_CHANNELS*eqsc_pkg::BAND_COUNT];
   logic [SAMPLE_BITS-1:0]         vol_mem  [MAX_CHANNELS];

   readout_type            readout_q [$];
   readout_type            predicted;
   logic [31:0]            reg_image;
   int                     errors = 0;
   int                     scans = 0;

   // length of a phase, a zero register still gives one tick
   function automatic logic [eqsc_pkg::TICK_BITS-1:0] phase_len(eqsc_pkg::phase_type ph);
      logic [eqsc_pkg::TICK_BITS-1:0] d;
      case (ph)
         eqsc_pkg::PH_RESET:  d = cfg_hold;
         eqsc_pkg::PH_LEAD:   d = cfg_lead;
         eqsc_pkg::PH_SETTLE: d = cfg_settle;
         default:             d = cfg_tail;
      endcase
      return (d == '0) ? eqsc_pkg::TICK_BITS'(1) : d;
   endfunction

   // one tick of the scan: advance the sequencer, capture, average, answer query
   task automatic step_scan(input logic start, input logic [3:0][SAMPLE_BITS-1:0] samples,
                            input logic [1:0] qc, input logic [2:0] qb,
                            output readout_type r);
      int   n;
      int   sum;
      logic finished;
      n = (int'(cfg_channels) > LANES) ? LANES : int'(cfg_channels);
      finished = 1'b0;
      if (scan_ph == eqsc_pkg::PH_IDLE) begin
         if (start) begin
            scan_ph  = eqsc_pkg::PH_RESET;
            ph_ticks = eqsc_pkg::TICK_BITS'(1);
            band_idx = '0;
         end
      end else if (ph_ticks < phase_len(scan_ph)) begin
         ph_ticks = ph_ticks + eqsc_pkg::TICK_BITS'(1);
      end else begin
         ph_ticks = eqsc_pkg::TICK_BITS'(1);
         case (scan_ph)
            eqsc_pkg::PH_RESET: begin
               scan_ph = eqsc_pkg::PH_LEAD;
            end
            eqsc_pkg::PH_LEAD: begin
               scan_ph  = eqsc_pkg::PH_SETTLE;
               band_idx = '0;
            end
            eqsc_pkg::PH_SETTLE: begin
               // first tail tick takes this word's samples
               scan_ph = eqsc_pkg::PH_TAIL;
               for (int ch = 0; ch < n; ch++)
                  band_mem[ch*eqsc_pkg::BAND_COUNT + int'(band_idx)] = samples[ch];
            end
            default: begin
               if (int'(band_idx) + 1 < eqsc_pkg::BAND_COUNT) begin
                  band_idx = band_idx + eqsc_pkg::BAND_BITS'(1);
                  scan_ph  = eqsc_pkg::PH_SETTLE;
               end else begin
                  // scan complete, volumes are the truncated band means
                  scan_ph  = eqsc_pkg::PH_IDLE;
                  ph_ticks = '0;
                  band_idx = '0;
                  for (int ch = 0; ch < n; ch++) begin
                     sum = 0;
                     for (int b = 0; b < eqsc_pkg::BAND_COUNT; b++)
                        sum += int'(band_mem[ch*eqsc_pkg::BAND_COUNT + b]);
                     vol_mem[ch] = SAMPLE_BITS'(sum / eqsc_pkg::BAND_COUNT);
                  end
                  finished = 1'b1;
               end
            end
         endcase
      end

      // query answer, zero outside the active channels or for band seven
      r.band_value = '0;
      r.volume     = '0;
      if (int'(qc) < n) begin
         r.volume = vol_mem[qc];
         if (int'(qb) < eqsc_pkg::BAND_COUNT)
            r.band_value = band_mem[int'(qc)*eqsc_pkg::BAND_COUNT + int'(qb)];
      end
      r.reset_pin  = (scan_ph == eqsc_pkg::PH_RESET);
      r.strobe_pin = (scan_ph == eqsc_pkg::PH_LEAD) || (scan_ph == eqsc_pkg::PH_TAIL);
      r.busy       = (scan_ph != eqsc_pkg::PH_IDLE);
      r.done       = finished;
   endtask

   task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] exp_val,
                              input logic [SAMPLE_BITS-1:0] act_val);
      if (act_val !== exp_val) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_channels = eqsc_pkg::ACTIVE_CHANNELS_RST;
         cfg_hold     = eqsc_pkg::RESET_HOLD_TICKS_RST;
         cfg_lead     = eqsc_pkg::STROBE_LEAD_TICKS_RST;
         cfg_settle   = eqsc_pkg::SETTLE_TICKS_RST;
         cfg_tail     = eqsc_pkg::STROBE_TAIL_TICKS_RST;
         scan_ph      = eqsc_pkg::PH_IDLE;
         ph_ticks     = '0;
         band_idx     = '0;
         for (int i = 0; i < MAX_CHANNELS*eqsc_pkg::BAND_COUNT; i++) band_mem[i] = '0;
         for (int i = 0; i < MAX_CHANNELS; i++) vol_mem[i] = '0;
         readout_q.delete();
      end else begin
         // register port, access phase
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[4:2])
                  eqsc_pkg::REG_ACTIVE_CHANNELS:
                     cfg_channels = csr_pwdata[eqsc_pkg::CHAN_BITS-1:0];
                  eqsc_pkg::REG_RESET_HOLD_TICKS:
                     cfg_hold     = csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
                  eqsc_pkg::REG_STROBE_LEAD_TICKS:
                     cfg_lead     = csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
                  eqsc_pkg::REG_SETTLE_TICKS:
                     cfg_settle   = csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
                  eqsc_pkg::REG_STROBE_TAIL_TICKS:
                     cfg_tail     = csr_pwdata[eqsc_pkg::TICK_BITS-1:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[4:2])
                  eqsc_pkg::REG_ACTIVE_CHANNELS:   reg_image = 32'(cfg_channels);
                  eqsc_pkg::REG_RESET_HOLD_TICKS:  reg_image = 32'(cfg_hold);
                  eqsc_pkg::REG_STROBE_LEAD_TICKS: reg_image = 32'(cfg_lead);
                  eqsc_pkg::REG_SETTLE_TICKS:      reg_image = 32'(cfg_settle);
                  eqsc_pkg::REG_STROBE_TAIL_TICKS: reg_image = 32'(cfg_tail);
                  default:                         reg_image = '0;
               endcase
               if (csr_prdata !== reg_image) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: register read at 0x%0h, expected 0x%0h, actual 0x%0h",
                              $time, csr_paddr, reg_image, csr_prdata);
               end
            end
         end

         // request word accepted
         if (req_valid && !req_stall) begin
            step_scan(req_start_scan,
                      {req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0},
                      req_query_channel, req_query_band, predicted);
            readout_q.push_back(predicted);
         end

         // response word accepted
         if (rsp_valid && !rsp_stall) begin
            if (readout_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: stray response, expected none, actual %0b%0b%0b%0b/%0d/%0d",
                           $time, rsp_reset_out, rsp_strobe_out, rsp_busy_res,
                           rsp_scan_done, rsp_band_value, rsp_channel_volume);
            end else begin
               predicted = readout_q.pop_front();
               check_field("reset_out", SAMPLE_BITS'(predicted.reset_pin),
                           SAMPLE_BITS'(rsp_reset_out));
               check_field("strobe_out", SAMPLE_BITS'(predicted.strobe_pin),
                           SAMPLE_BITS'(rsp_strobe_out));
               check_field("busy_res", SAMPLE_BITS'(predicted.busy),
                           SAMPLE_BITS'(rsp_busy_res));
               check_field("scan_done", SAMPLE_BITS'(predicted.done),
                           SAMPLE_BITS'(rsp_scan_done));
               check_field("band_value", predicted.band_value, rsp_band_value);
               check_field("channel_volume", predicted.volume, rsp_channel_volume);
               if (predicted.done) scans++;
            end
         end
      end
      pending_words <= readout_q.size();
      fail_count    <= errors;
      scans_seen    <= scans;
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the band equalizer scan controller. A directed
// run covers reset values, query edges, zero-length phases and ignored
// starts; random tick streams then run under a series of register settings,
// from one-tick phases to phases of twenty ticks, with changing idle patterns
// on both channels. Checking is done by the scoreboard instance beside the
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 50000;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_scan = 1'b0;
   logic [11:0] req_sample_ch0 = '0;
   logic [11:0] req_sample_ch1 = '0;
   logic [11:0] req_sample_ch2 = '0;
   logic [11:0] req_sample_ch3 = '0;
   logic [1:0]  req_query_channel = '0;
   logic [2:0]  req_query_band = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_reset_out;
   logic        rsp_strobe_out;
   logic        rsp_busy_res;
   logic        rsp_scan_done;
   logic [11:0] rsp_band_value;
   logic [11:0] rsp_channel_volume;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          chk_fails;
   int          chk_pending;
   int          chk_scans;
   int          gap_pct = 0;
   int          stall_pct = 0;
   int          words_sent = 0;
   int          settings_used = 0;
   int          cycle_count = 0;

   band_equalizer_scan_controller_top #(
      .MAX_CHANNELS(4),
      .SAMPLE_BITS (12)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_scan    (req_start_scan),
      .req_sample_ch0    (req_sample_ch0),
      .req_sample_ch1    (req_sample_ch1),
      .req_sample_ch2    (req_sample_ch2),
      .req_sample_ch3    (req_sample_ch3),
      .req_query_channel (req_query_channel),
      .req_query_band    (req_query_band),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reset_out     (rsp_reset_out),
      .rsp_strobe_out    (rsp_strobe_out),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_scan_done     (rsp_scan_done),
      .rsp_band_value    (rsp_band_value),
      .rsp_channel_volume(rsp_channel_volume),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   eqsc_checker #(
      .MAX_CHANNELS(4),
      .SAMPLE_BITS (12)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_scan    (req_start_scan),
      .req_sample_ch0    (req_sample_ch0),
      .req_sample_ch1    (req_sample_ch1),
      .req_sample_ch2    (req_sample_ch2),
      .req_sample_ch3    (req_sample_ch3),
      .req_query_channel (req_query_channel),
      .req_query_band    (req_query_band),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reset_out     (rsp_reset_out),
      .rsp_strobe_out    (rsp_strobe_out),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_scan_done     (rsp_scan_done),
      .rsp_band_value    (rsp_band_value),
      .rsp_channel_volume(rsp_channel_volume),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .fail_count        (chk_fails),
      .pending_words     (chk_pending),
      .scans_seen        (chk_scans)
   );

   // clock and cycle counter
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, chk_pending);
      $display("** band_equalizer_scan_controller_top: FAILED **");
      $finish;
   end

   // sample values lean on the extremes now and then
   function automatic logic [11:0] pick_sample();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return 12'($urandom);
      endcase
   endfunction

   // one request word, with random idle cycles ahead of it
   task automatic send_word(input logic start, input logic [11:0] s0, input logic [11:0] s1,
                            input logic [11:0] s2, input logic [11:0] s3,
                            input logic [1:0] qc, input logic [2:0] qb);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_scan    <= start;
      req_sample_ch0    <= s0;
      req_sample_ch1    <= s1;
      req_sample_ch2    <= s2;
      req_sample_ch3    <= s3;
      req_query_channel <= qc;
      req_query_band    <= qb;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // stop sending and wait for every expected word
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (chk_pending != 0);
      repeat (2) @(posedge clock);
   endtask

   // setup then access phase, psel stays up for the next access
   task automatic csr_access(input logic write, input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // read back every register, the scoreboard compares
   task automatic check_regs();
      csr_access(1'b0, eqsc_pkg::REG_ACTIVE_CHANNELS, '0);
      csr_access(1'b0, eqsc_pkg::REG_RESET_HOLD_TICKS, '0);
      csr_access(1'b0, eqsc_pkg::REG_STROBE_LEAD_TICKS, '0);
      csr_access(1'b0, eqsc_pkg::REG_SETTLE_TICKS, '0);
      csr_access(1'b0, eqsc_pkg::REG_STROBE_TAIL_TICKS, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input int ac, input int hold, input int lead,
                                 input int settle, input int tail);
      csr_access(1'b1, eqsc_pkg::REG_ACTIVE_CHANNELS, 32'(ac));
      csr_access(1'b1, eqsc_pkg::REG_RESET_HOLD_TICKS, 32'(hold));
      csr_access(1'b1, eqsc_pkg::REG_STROBE_LEAD_TICKS, 32'(lead));
      csr_access(1'b1, eqsc_pkg::REG_SETTLE_TICKS, 32'(settle));
      csr_access(1'b1, eqsc_pkg::REG_STROBE_TAIL_TICKS, 32'(tail));
      check_regs();
      settings_used++;
   endtask

   // one register setting with a random tick stream, long enough for some scans
   task automatic run_setting(input int ac, input int hold, input int lead, input int settle,
                              input int tail, input flow_type flow, input int min_words,
                              input int min_scans, input bit pause_mid);
      int count;
      int base;
      drain();
      apply_settings(ac, hold, lead, settle, tail);
      case (flow)
         FLOW_SENDER_IDLE:    begin gap_pct = 86; stall_pct = 0;  end
         FLOW_RECEIVER_STALL: begin gap_pct = 0;  stall_pct = 86; end
         FLOW_BOTH:           begin gap_pct = 30; stall_pct = 30; end
         default:             begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      base  = chk_scans;
      count = 0;
      while (count < min_words || chk_scans - base < min_scans) begin
         if (pause_mid && count == min_words / 2) drain();
         send_word($urandom_range(3) == 0, pick_sample(), pick_sample(), pick_sample(),
                   pick_sample(), 2'($urandom), 3'($urandom));
         count++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers, queries of the cleared stores
      check_regs();
      send_word(1'b0, '1, '1, '1, '1, 2'd0, 3'd0);
      send_word(1'b0, '0, '0, '0, '0, 2'd3, 3'd7);

      // all four channels, every phase register zero so each phase is one tick
      drain();
      apply_settings(4, 0, 0, 0, 0);
      send_word(1'b1, '0, '0, '0, '0, 2'd0, 3'd0);
      for (int i = 0; i < 16; i++) begin
         logic [11:0] level;
         level = (i % 4 == 2) ? 12'hFFF : 12'h000;
         // starts on the busy tick and on the completing tick are ignored
         send_word((i == 1) || (i == 15), level, ~level, 12'(12'hA5A ^ i), 12'h5A5,
                   2'(i), 3'(i));
      end
      for (int q = 0; q < 4; q++)
         send_word(1'b0, '0, '0, '0, '0, 2'(q), (q == 3) ? 3'd7 : 3'(2 * q));

      // random streams under a range of settings
      run_setting(4, 1, 1, 1, 1, FLOW_SENDER_IDLE, 40, 2, 1'b1);
      run_setting(0, 0, 0, 0, 0, FLOW_RECEIVER_STALL, 30, 2, 1'b0);
      run_setting(7, $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                  $urandom_range(4, 1), FLOW_BOTH, 30, 1, 1'b0);
      run_setting(3, 20, 8, 3, 3, FLOW_FREE, 30, 1, 1'b0);
      run_setting(5, $urandom_range(6), $urandom_range(6), $urandom_range(6),
                  $urandom_range(6), FLOW_SENDER_IDLE, 30, 1, 1'b0);
      run_setting(1, 3, 5, 2, 2, FLOW_BOTH, 30, 1, 1'b0);
      run_setting(2, $urandom_range(5, 1), $urandom_range(5, 1), $urandom_range(5, 1),
                  $urandom_range(5, 1), FLOW_RECEIVER_STALL, 30, 1, 1'b0);
      run_setting(6, 9, 1, 1, 4, FLOW_FREE, 30, 1, 1'b0);
      run_setting(4, $urandom_range(3), $urandom_range(3), $urandom_range(3),
                  $urandom_range(3), FLOW_BOTH, 30, 1, 1'b0);

      // let the last words come back
      drain();
      repeat (4) @(posedge clock);

      $display("run covered %0d request words under %0d register settings", words_sent,
               settings_used);
      $display("%0d scans completed, channel counts 0 to 7, phases from 1 to 20 ticks",
               chk_scans);
      if (chk_fails == 0 && chk_pending == 0) begin
         $display("** band_equalizer_scan_controller_top: PASSED **");
      end else begin
         $display("** band_equalizer_scan_controller_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/eqsc_pkg.sv
rtl/eqsc_sequencer.sv
rtl/eqsc_lane.sv
rtl/eqsc_query_merge.sv
rtl/band_equalizer_scan_controller_top.sv
tb/eqsc_checker.sv
tb/tb.sv
